@@ design/rmis_pkg.sv @@
// Shared types, constants and the microcode table of the ring memory instruction step block.
package rmis_pkg;

  // Default memory depth and fixed field widths.
  localparam int RMIS_MEM_SIZE = 1024;
  localparam int FUNC_W        = 2;
  localparam int LOC_W         = 10;
  localparam int BYTE_W        = 8;

  // Configuration port shape and register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_EN = 1'b1;

  // Opcode bits that mark an offset as an absolute address.
  localparam int OPC_ABS_S1_BIT = 7;
  localparam int OPC_ABS_S2_BIT = 6;
  localparam int OPC_ABS_D_BIT  = 5;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  // Item kinds.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_EXEC = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  // Operations chosen by the low opcode bits.
  typedef enum logic [1:0] {
    ALU_INV    = 2'd0,
    ALU_AND    = 2'd1,
    ALU_ADD    = 2'd2,
    ALU_SUBSAT = 2'd3
  } alu_op_t;

  // Memory address source for a step.
  typedef enum logic [2:0] {
    ASEL_ENTRY = 3'd0,
    ASEL_E1    = 3'd1,
    ASEL_E2    = 3'd2,
    ASEL_E3    = 3'd3,
    ASEL_S1    = 3'd4,
    ASEL_S2    = 3'd5,
    ASEL_D     = 3'd6
  } addr_sel_t;

  // Register that captures the read data of the previous step.
  typedef enum logic [2:0] {
    LAT_NONE = 3'd0,
    LAT_OP   = 3'd1,
    LAT_S1   = 3'd2,
    LAT_S2   = 3'd3,
    LAT_D    = 3'd4,
    LAT_A    = 3'd5
  } latch_t;

  typedef enum logic {
    WD_LOAD = 1'b0,
    WD_ALU  = 1'b1
  } wdata_sel_t;

  typedef enum logic [1:0] {
    RB_ZERO = 2'd0,
    RB_MEMQ = 2'd1,
    RB_ALU  = 2'd2
  } rb_sel_t;

  typedef enum logic [1:0] {
    WL_ZERO  = 2'd0,
    WL_ENTRY = 2'd1,
    WL_DEST  = 2'd2
  } wl_sel_t;

  typedef enum logic {
    SEQ_NEXT = 1'b0,
    SEQ_END  = 1'b1
  } seq_t;

  // One control word of the microprogram.
  typedef struct packed {
    addr_sel_t  addr_sel;
    logic       mem_we;
    wdata_sel_t wdata_sel;
    latch_t     latch;
    logic       emit;
    rb_sel_t    rb_sel;
    wl_sel_t    wl_sel;
    logic       dw;
    seq_t       seq;
  } ctrl_word_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    logic       accept;
    logic       step;
    ctrl_word_t cw;
  } dp_ctrl_t;

  // Microprogram counter and entry points.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_LOAD = 4'd0;
  localparam logic [UPC_W-1:0] UPC_READ = 4'd1;
  localparam logic [UPC_W-1:0] UPC_EXEC = 4'd3;
  localparam logic [UPC_W-1:0] UPC_NONE = 4'd10;

  // Entry point of the routine for each item kind.
  function automatic logic [UPC_W-1:0] entry_upc(func_t f);
    logic [UPC_W-1:0] upc;
    unique case (f)
      FUNC_LOAD: upc = UPC_LOAD;
      FUNC_READ: upc = UPC_READ;
      FUNC_EXEC: upc = UPC_EXEC;
      default:   upc = UPC_NONE;
    endcase
    return upc;
  endfunction

  // Microcode table. Read data of a step appears in the following step.
  function automatic ctrl_word_t ucode_rom(logic [UPC_W-1:0] upc);
    ctrl_word_t cw;
    cw = '{addr_sel: ASEL_ENTRY, mem_we: 1'b0, wdata_sel: WD_LOAD, latch: LAT_NONE,
           emit: 1'b0, rb_sel: RB_ZERO, wl_sel: WL_ZERO, dw: 1'b0, seq: SEQ_NEXT};
    unique case (upc)
      // Load: write the byte and report the location.
      4'd0: begin
        cw.mem_we = 1'b1;
        cw.emit   = 1'b1;
        cw.wl_sel = WL_ENTRY;
        cw.dw     = 1'b1;
        cw.seq    = SEQ_END;
      end
      // Read: fetch, then report the byte.
      4'd1: cw.addr_sel = ASEL_ENTRY;
      4'd2: begin
        cw.emit   = 1'b1;
        cw.rb_sel = RB_MEMQ;
        cw.seq    = SEQ_END;
      end
      // Execute: fetch the four instruction bytes and the two operands.
      4'd3: cw.addr_sel = ASEL_ENTRY;
      4'd4: begin
        cw.addr_sel = ASEL_E1;
        cw.latch    = LAT_OP;
      end
      4'd5: begin
        cw.addr_sel = ASEL_E2;
        cw.latch    = LAT_S1;
      end
      4'd6: begin
        cw.addr_sel = ASEL_E3;
        cw.latch    = LAT_S2;
      end
      4'd7: begin
        cw.addr_sel = ASEL_S1;
        cw.latch    = LAT_D;
      end
      4'd8: begin
        cw.addr_sel = ASEL_S2;
        cw.latch    = LAT_A;
      end
      // Compute with the second operand straight from memory and deposit the result.
      4'd9: begin
        cw.addr_sel  = ASEL_D;
        cw.mem_we    = 1'b1;
        cw.wdata_sel = WD_ALU;
        cw.emit      = 1'b1;
        cw.rb_sel    = RB_ALU;
        cw.wl_sel    = WL_DEST;
        cw.dw        = 1'b1;
        cw.seq       = SEQ_END;
      end
      // Unused item kind: an all-zero result.
      4'd10: begin
        cw.emit = 1'b1;
        cw.seq  = SEQ_END;
      end
      default: cw.seq = SEQ_END;
    endcase
    return cw;
  endfunction

endpackage

@@ design/rmis_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface rmis_in_if
  import rmis_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [LOC_W-1:0]  location;
  logic [BYTE_W-1:0] load_value;

  modport source (output valid, output func, output location, output load_value, input ready);
  modport sink   (input valid, input func, input location, input load_value, output ready);
endinterface

interface rmis_out_if
  import rmis_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;
  logic [LOC_W-1:0]  written_location;
  logic              did_write;

  modport source (output valid, output result_byte, output written_location,
                  output did_write, input ready);
  modport sink   (input valid, input result_byte, input written_location,
                  input did_write, output ready);
endinterface

@@ design/rmis_ram.sv @@
// Single-port byte memory with a registered read.
module rmis_ram
  import rmis_pkg::*;
#(
  parameter int DEPTH  = RMIS_MEM_SIZE,
  parameter int ADDR_W = $clog2(RMIS_MEM_SIZE)
) (
  input  logic              clk,
  input  logic              re,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/rmis_ctrl.sv @@
// Microcode sequencer: step counter, dispatch, control word fetch and channel handshakes.
module rmis_ctrl
  import rmis_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dp_ctrl_t          ctrl
);

  logic             busy_r;
  logic [UPC_W-1:0] upc_r;
  logic             out_valid_r;
  ctrl_word_t       cw;
  logic             accept;
  logic             stall;
  logic             step;

  // Current control word and step qualification.
  assign cw       = ucode_rom(upc_r);
  assign in_ready = !busy_r;
  assign accept   = in_valid && !busy_r;
  assign stall    = cw.emit && out_valid_r && !out_ready;
  assign step     = busy_r && !stall;

  // Step counter: dispatch on the item kind, then count or finish.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= UPC_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        upc_r  <= entry_upc(func_t'(in_func));
      end else if (step) begin
        if (cw.seq == SEQ_END) begin
          busy_r <= 1'b0;
        end else begin
          upc_r <= upc_r + UPC_W'(1);
        end
      end
      // Result register: loaded by an emitting step, emptied by a transaction.
      if (step && cw.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign ctrl.accept = accept;
  assign ctrl.step   = step;
  assign ctrl.cw     = cw;

endmodule

@@ design/rmis_dp.sv @@
// Datapath: instruction registers, ring address generation, operation unit and result register.
module rmis_dp
  import rmis_pkg::*;
#(
  parameter int MEM_SIZE = RMIS_MEM_SIZE,
  parameter int ADDR_W   = $clog2(RMIS_MEM_SIZE)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_ctrl_t              ctrl,
  input  logic [LOC_W-1:0]      in_location,
  input  logic [BYTE_W-1:0]     in_load_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  mem_re,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_addr,
  output logic [BYTE_W-1:0]     mem_wdata,
  input  logic [BYTE_W-1:0]     mem_rdata,
  output logic [BYTE_W-1:0]     out_result_byte,
  output logic [LOC_W-1:0]      out_written_location,
  output logic                  out_did_write
);

  localparam int SUM_W       = ADDR_W + 1;
  localparam int RED_W       = ((ADDR_W > LOC_W) ? ADDR_W : LOC_W) + 1;
  localparam int RING_PASSES = ((1 << LOC_W) - 1) / MEM_SIZE;
  localparam logic [SUM_W-1:0] MEM_SIZE_S = SUM_W'(MEM_SIZE);
  localparam logic [RED_W-1:0] MEM_SIZE_R = RED_W'(MEM_SIZE);

  logic              abs_en_r;
  logic              dec_en_r;
  logic [ADDR_W-1:0] entry_r;
  logic [BYTE_W-1:0] load_val_r;
  logic [BYTE_W-1:0] op_r;
  logic [BYTE_W-1:0] s1_r;
  logic [BYTE_W-1:0] s2_r;
  logic [BYTE_W-1:0] d_r;
  logic [BYTE_W-1:0] a_r;
  logic [BYTE_W-1:0] rb_r;
  logic [LOC_W-1:0]  wl_r;
  logic              dw_r;
  logic [ADDR_W-1:0] dest_addr;
  logic [BYTE_W-1:0] alu_res;
  alu_op_t           alu_sel;
  ctrl_word_t        cw;

  // Entry plus an offset below the memory size: one compare and subtract wraps it.
  function automatic logic [ADDR_W-1:0] ring_add(logic [ADDR_W-1:0] base,
                                                 logic [BYTE_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + SUM_W'(off);
    if (sum >= MEM_SIZE_S) begin
      sum = sum - MEM_SIZE_S;
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Reduce an incoming location into the ring; a few subtractions suffice.
  function automatic logic [ADDR_W-1:0] ring_loc(logic [LOC_W-1:0] loc);
    logic [RED_W-1:0] v;
    v = RED_W'(loc);
    for (int i = 0; i < RING_PASSES; i++) begin
      if (v >= MEM_SIZE_R) begin
        v = v - MEM_SIZE_R;
      end
    end
    return v[ADDR_W-1:0];
  endfunction

  assign cw = ctrl.cw;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_en_r <= 1'b0;
      dec_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ABS_EN: abs_en_r <= cfg_data[0];
        CFG_DEC_EN: dec_en_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Destination address, relative or absolute.
  assign dest_addr = (abs_en_r && op_r[OPC_ABS_D_BIT]) ? ADDR_W'(d_r) : ring_add(entry_r, d_r);

  // Memory address for the current step.
  always_comb begin
    unique case (cw.addr_sel)
      ASEL_ENTRY: mem_addr = entry_r;
      ASEL_E1:    mem_addr = ring_add(entry_r, BYTE_W'(1));
      ASEL_E2:    mem_addr = ring_add(entry_r, BYTE_W'(2));
      ASEL_E3:    mem_addr = ring_add(entry_r, BYTE_W'(3));
      ASEL_S1:    mem_addr = (abs_en_r && op_r[OPC_ABS_S1_BIT]) ? ADDR_W'(s1_r)
                                                                 : ring_add(entry_r, s1_r);
      ASEL_S2:    mem_addr = (abs_en_r && op_r[OPC_ABS_S2_BIT]) ? ADDR_W'(s2_r)
                                                                 : ring_add(entry_r, s2_r);
      ASEL_D:     mem_addr = dest_addr;
      default:    mem_addr = entry_r;
    endcase
  end

  // Operation unit: first operand registered, second straight from the memory read.
  assign alu_sel = dec_en_r ? alu_op_t'(op_r[1:0]) : ALU_SUBSAT;

  always_comb begin
    unique case (alu_sel)
      ALU_INV:    alu_res = BYTE_MAX - a_r;
      ALU_AND:    alu_res = a_r & mem_rdata;
      ALU_ADD:    alu_res = a_r + mem_rdata;
      ALU_SUBSAT: alu_res = (a_r > mem_rdata) ? (a_r - mem_rdata) : '0;
      default:    alu_res = '0;
    endcase
  end

  assign mem_re    = ctrl.step;
  assign mem_we    = ctrl.step && cw.mem_we;
  assign mem_wdata = (cw.wdata_sel == WD_ALU) ? alu_res : load_val_r;

  // Item capture, instruction byte capture and the result register payload.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      entry_r    <= ring_loc(in_location);
      load_val_r <= in_load_value;
    end
    if (ctrl.step) begin
      case (cw.latch)
        LAT_OP:  op_r <= mem_rdata;
        LAT_S1:  s1_r <= mem_rdata;
        LAT_S2:  s2_r <= mem_rdata;
        LAT_D:   d_r  <= mem_rdata;
        LAT_A:   a_r  <= mem_rdata;
        default: ;
      endcase
    end
    if (ctrl.step && cw.emit) begin
      case (cw.rb_sel)
        RB_MEMQ: rb_r <= mem_rdata;
        RB_ALU:  rb_r <= alu_res;
        default: rb_r <= '0;
      endcase
      case (cw.wl_sel)
        WL_ENTRY: wl_r <= LOC_W'(entry_r);
        WL_DEST:  wl_r <= LOC_W'(dest_addr);
        default:  wl_r <= '0;
      endcase
      dw_r <= cw.dw;
    end
  end

  assign out_result_byte      = rb_r;
  assign out_written_location = wl_r;
  assign out_did_write        = dw_r;

endmodule

@@ design/ring_memory_instruction_step_top.sv @@
// Top level of the ring memory instruction step block.
// A ring of MEM_SIZE bytes in a single-port memory, run by a short microprogram. Every item
// gives exactly one result. An execute makes six dependent reads and one write through the
// one memory port, one access per microcode step. A new item is accepted once the previous
// routine has ended, even while its result waits in the output register. The memory holds no
// reset value: every byte must be loaded before it is read or executed. Configuration must
// be written only while the block is idle.
module ring_memory_instruction_step_top
  import rmis_pkg::*;
#(
  parameter int MEM_SIZE = RMIS_MEM_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rmis_in_if.sink               in_ch,
  rmis_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MEM_SIZE);

  dp_ctrl_t          ctrl;
  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  // Sequencer.
  rmis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  // Datapath.
  rmis_dp #(
    .MEM_SIZE (MEM_SIZE),
    .ADDR_W   (ADDR_W)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctrl                 (ctrl),
    .in_location          (in_ch.location),
    .in_load_value        (in_ch.load_value),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .mem_re               (mem_re),
    .mem_we               (mem_we),
    .mem_addr             (mem_addr),
    .mem_wdata            (mem_wdata),
    .mem_rdata            (mem_rdata),
    .out_result_byte      (out_ch.result_byte),
    .out_written_location (out_ch.written_location),
    .out_did_write        (out_ch.did_write)
  );

  // Ring memory.
  rmis_ram #(
    .DEPTH  (MEM_SIZE),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .re    (mem_re),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
